[rtl/core/fdr_pkg.sv]
// Shared types and constants for the Fresnel dielectric reflectance pipeline.
package fdr_pkg;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [16:0] ONE_Q15 = 17'h0_8000;
	localparam logic [16:0] WRAP_Q16 = 17'h1_0000;
	localparam logic [15:0] MAX_POS_Q15 = 16'h7FFF;
	localparam logic [15:0] RESET_INDEX_OUTSIDE = 16'd16384;
	localparam logic [15:0] RESET_INDEX_INSIDE = 16'd24576;
	localparam logic [1:0] REG_INDEX_OUTSIDE = 2'd0;
	localparam logic [1:0] REG_INDEX_INSIDE = 2'd1;

	localparam int SIN2_QW = 30;
	localparam int SQRT_STEPS = 16;
	localparam int AMP_QW = 25;
	localparam int LATENCY = 4 + SIN2_QW + 1 + SQRT_STEPS + 2 + AMP_QW + 2;

	// Per-item data that travels alongside the arithmetic.
	typedef struct packed {
		logic        tir;
		logic        entering;
		logic        eq;
		logic        z_s;
		logic        z_p;
		logic [16:0] c;
		logic [15:0] ei;
		logic [15:0] et;
		logic [15:0] t;
	} side_t;

endpackage

[rtl/core/fresnel_dielectric_reflectance_top.sv]
// Fresnel dielectric reflectance: top level with the full arithmetic pipeline.
//
// One cosine is taken in every cycle (busy stays low) and its result appears
// on the result ports, marked by done for one cycle. The pipeline depth is set
// by the pipelined 30-bit divider for sin^2, the 16-step square root and the
// 25-bit divider for the amplitude ratios, each resolving one bit per stage.
// The receiver cannot stall, so nothing is held back. Index registers are
// captured with each item on entry.
module fresnel_dielectric_reflectance_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  cos_incident,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output logic [15:0]         reflectance,
	output logic signed [15:0]  cos_transmitted,
	output logic                total_internal
);

	import fdr_pkg::*;

	logic [15:0] index_outside_q, index_inside_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_outside_q <= RESET_INDEX_OUTSIDE;
			index_inside_q  <= RESET_INDEX_INSIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INDEX_OUTSIDE: index_outside_q <= cfg_data;
				REG_INDEX_INSIDE:  index_inside_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: side selection.
	logic        neg, entering;
	logic [16:0] c_w;
	side_t       side_w;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;

	assign neg      = cos_incident[15];
	assign entering = !neg && (cos_incident != 16'sd0);
	assign c_w      = neg ? 17'(WRAP_Q16 - {1'b0, cos_incident}) : {1'b0, cos_incident};

	always_comb begin
		side_w          = '0;
		side_w.entering = entering;
		side_w.c        = c_w;
		side_w.ei       = entering ? index_outside_q : index_inside_q;
		side_w.et       = entering ? index_inside_q : index_outside_q;
		side_w.eq       = index_outside_q == index_inside_q;
	end

	// Stage 2: squares. Stage 3: Snell numerator. Stage 4: total internal test.
	logic [31:0] ei2_s2, et2_s2, et2_s3, et2_s4;
	logic [30:0] omc_s2;
	logic [33:0] c2;
	logic [62:0] lhs_s3, lhs_s4;
	side_t       side_tir_w;

	assign c2 = 34'(side_s1.c) * 34'(side_s1.c);

	always_comb begin
		side_tir_w     = side_s3;
		side_tir_w.tir = lhs_s3 >= {1'b0, et2_s3, 30'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_w;
		side_s2 <= side_s1;
		ei2_s2  <= 32'(side_s1.ei) * 32'(side_s1.ei);
		et2_s2  <= 32'(side_s1.et) * 32'(side_s1.et);
		omc_s2  <= 31'(34'(ONE_Q30) - c2);
		side_s3 <= side_s2;
		lhs_s3  <= 63'(ei2_s2) * 63'(omc_s2);
		et2_s3  <= et2_s2;
		side_s4 <= side_tir_w;
		lhs_s4  <= lhs_s3;
		et2_s4  <= et2_s3;
	end

	// sin^2 of the transmitted angle, Q0.30.
	logic [SIN2_QW-1:0] sin2;
	side_t side_a [0:SIN2_QW];
	logic  v_a    [0:SIN2_QW];

	fdr_div #(.NW(63), .DW(32), .QW(SIN2_QW)) u_div_sin2 (
		.clk (clk),
		.num (lhs_s4),
		.den (et2_s4),
		.quo (sin2)
	);

	assign side_a[0] = side_s4;
	assign v_a[0]    = v_s4;

	for (genvar k = 0; k < SIN2_QW; k++) begin : g_dly_a
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_a[k+1] <= 1'b0;
			end else begin
				v_a[k+1] <= v_a[k];
			end
		end
		always_ff @(posedge clk) begin
			side_a[k+1] <= side_a[k];
		end
	end

	// Stage 5: radicand 1 - sin^2.
	logic [30:0] rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_a[SIN2_QW];
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_a[SIN2_QW];
		rad_s5  <= 31'(ONE_Q30 - 31'(sin2));
	end

	// Square root, one result bit per stage; rem holds rad - res^2.
	logic [30:0] rem_q [0:SQRT_STEPS];
	logic [15:0] res_q [0:SQRT_STEPS];
	side_t side_b [0:SQRT_STEPS];
	logic  v_b    [0:SQRT_STEPS];

	assign rem_q[0]  = rad_s5;
	assign res_q[0]  = '0;
	assign side_b[0] = side_s5;
	assign v_b[0]    = v_s5;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int I = SQRT_STEPS - 1 - k;
		logic [32:0] trial;
		logic        take;

		assign trial = (33'(res_q[k]) << (I + 1)) + (33'(1) << (2 * I));
		assign take  = 33'(rem_q[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_b[k+1] <= 1'b0;
			end else begin
				v_b[k+1] <= v_b[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_q[k+1]  <= take ? 31'(33'(rem_q[k]) - trial) : rem_q[k];
			res_q[k+1]  <= res_q[k] | (16'(take) << I);
			side_b[k+1] <= side_b[k];
		end
	end

	// Stage 6: cross products. Stage 7: amplitude sums and differences.
	side_t       side_s6, side_s7;
	logic        v_s6, v_s7;
	logic [32:0] a_s6, b_s6, cc_s6, d_s6;
	logic [33:0] den_s_s7, den_p_s7;
	logic [56:0] num_s_s7, num_p_s7;
	logic [33:0] sum_s, sum_p;
	logic [32:0] dif_s, dif_p;
	side_t       side_t_w, side_z_w;

	assign sum_s = 34'(a_s6) + 34'(b_s6);
	assign sum_p = 34'(cc_s6) + 34'(d_s6);
	assign dif_s = (a_s6 > b_s6) ? a_s6 - b_s6 : b_s6 - a_s6;
	assign dif_p = (cc_s6 > d_s6) ? cc_s6 - d_s6 : d_s6 - cc_s6;

	always_comb begin
		side_t_w   = side_b[SQRT_STEPS];
		side_t_w.t = res_q[SQRT_STEPS];
	end

	always_comb begin
		side_z_w     = side_s6;
		side_z_w.z_s = sum_s == '0;
		side_z_w.z_p = sum_p == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= v_b[SQRT_STEPS];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_t_w;
		a_s6  <= 33'(side_b[SQRT_STEPS].ei) * 33'(side_b[SQRT_STEPS].c);
		b_s6  <= 33'(side_b[SQRT_STEPS].et) * 33'(res_q[SQRT_STEPS]);
		cc_s6 <= 33'(side_b[SQRT_STEPS].et) * 33'(side_b[SQRT_STEPS].c);
		d_s6  <= 33'(side_b[SQRT_STEPS].ei) * 33'(res_q[SQRT_STEPS]);
		side_s7  <= side_z_w;
		den_s_s7 <= sum_s;
		den_p_s7 <= sum_p;
		num_s_s7 <= {dif_s, 24'b0};
		num_p_s7 <= {dif_p, 24'b0};
	end

	// Amplitude ratios in Q1.24.
	logic [AMP_QW-1:0] q_s, q_p;
	side_t side_c [0:AMP_QW];
	logic  v_c    [0:AMP_QW];

	fdr_div #(.NW(57), .DW(34), .QW(AMP_QW)) u_div_rs (
		.clk (clk),
		.num (num_s_s7),
		.den (den_s_s7),
		.quo (q_s)
	);

	fdr_div #(.NW(57), .DW(34), .QW(AMP_QW)) u_div_rp (
		.clk (clk),
		.num (num_p_s7),
		.den (den_p_s7),
		.quo (q_p)
	);

	assign side_c[0] = side_s7;
	assign v_c[0]    = v_s7;

	for (genvar k = 0; k < AMP_QW; k++) begin : g_dly_c
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[k+1] <= 1'b0;
			end else begin
				v_c[k+1] <= v_c[k];
			end
		end
		always_ff @(posedge clk) begin
			side_c[k+1] <= side_c[k];
		end
	end

	// Stage 8: squared ratios. Stage 9: mean and output formatting.
	side_t             side_s8;
	logic              v_s8, v_s9;
	logic [AMP_QW-1:0] rs, rp;
	logic [49:0]       sq_s_s8, sq_p_s8;
	logic [50:0]       sq_sum;
	logic [16:0]       refl_raw, refl_w, t17;
	logic [15:0]       cos_w;
	logic [15:0]       refl_s9, cos_s9;
	logic              tir_s9;

	assign rs = side_c[AMP_QW].z_s ? AMP_QW'(1) << 24 : q_s;
	assign rp = side_c[AMP_QW].z_p ? AMP_QW'(1) << 24 : q_p;

	assign sq_sum   = 51'(sq_s_s8) + 51'(sq_p_s8);
	assign refl_raw = sq_sum[50:34];
	assign t17      = {1'b0, side_s8.t};

	always_comb begin
		if (side_s8.tir) begin
			refl_w = ONE_Q15;
			cos_w  = '0;
		end else begin
			if (side_s8.eq) begin
				refl_w = '0;
			end else begin
				refl_w = (refl_raw > ONE_Q15) ? ONE_Q15 : refl_raw;
			end
			if (side_s8.entering) begin
				cos_w = 16'(WRAP_Q16 - t17);
			end else begin
				cos_w = (t17 > 17'(MAX_POS_Q15)) ? MAX_POS_Q15 : side_s8.t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s8 <= v_c[AMP_QW];
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		side_s8 <= side_c[AMP_QW];
		sq_s_s8 <= 50'(rs) * 50'(rs);
		sq_p_s8 <= 50'(rp) * 50'(rp);
		refl_s9 <= refl_w[15:0];
		cos_s9  <= cos_w;
		tir_s9  <= side_s8.tir;
	end

	assign done            = v_s9;
	assign reflectance     = refl_s9;
	assign cos_transmitted = cos_s9;
	assign total_internal  = tir_s9;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LATENCY) done)
		else $error("result strobe did not follow a start beat at the pipeline latency");

	a_tir_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && total_internal) |-> (reflectance == 16'h8000 && cos_transmitted == 16'sd0))
		else $error("total internal reflection beat carries wrong values");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reflectance <= 16'h8000))
		else $error("reflectance above one");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(start))
		else $error("pipeline entry without a start beat");

endmodule

[rtl/core/fdr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module fdr_div #(
	parameter int NW = 63,
	parameter int DW = 32,
	parameter int QW = 30
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int W = NW + DW;

	logic [NW-1:0] rem_r [0:QW];
	logic [DW-1:0] den_r [0:QW];
	logic [QW-1:0] q_r   [0:QW];

	assign rem_r[0] = num;
	assign den_r[0] = den;
	assign q_r[0]   = '0;

	// The quotient is assumed to fit in QW bits; callers discard it otherwise.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int I = QW - 1 - k;
		logic [W-1:0] trial;
		logic [W-1:0] rem_w;
		logic         take;

		assign trial = W'(den_r[k]) << I;
		assign rem_w = W'(rem_r[k]);
		assign take  = rem_w >= trial;

		always_ff @(posedge clk) begin
			rem_r[k+1] <= take ? NW'(rem_w - trial) : rem_r[k];
			den_r[k+1] <= den_r[k];
			q_r[k+1]   <= q_r[k] | (QW'(take) << I);
		end
	end

	assign quo = q_r[QW];

endmodule

[bench/fresnel_dielectric_reflectance_top_tb.sv]
// Self-checking testbench for the Fresnel dielectric reflectance block.
module fresnel_dielectric_reflectance_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdr_pkg::*;

	localparam int MAX_CYCLES = 400000;

	typedef struct {
		logic [15:0] refl;
		logic [15:0] cos_t;
		logic        tir;
	} fresnel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] cos_incident = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_INDEX_OUTSIDE;
	logic [15:0] cfg_data = '0;
	logic done;
	logic [15:0] reflectance;
	logic signed [15:0] cos_transmitted;
	logic total_internal;

	fresnel_dielectric_reflectance_top dut (.*);

	always #6 clk = ~clk;

	// Pending cosines, each with its pre-drawn idle gap, and the expected results.
	logic [15:0] cos_pending[$];
	int gap_pending[$];
	fresnel_result_t expected_results[$];
	logic [15:0] n_out = RESET_INDEX_OUTSIDE;
	logic [15:0] n_in = RESET_INDEX_INSIDE;
	int errors = 0;
	int cycles = 0;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] ratio_q24(logic [63:0] x, logic [63:0] y);
		logic [63:0] den, diff;
		den = x + y;
		diff = x > y ? x - y : y - x;
		if (den == 0) return 64'd1 << 24;
		return (diff << 24) / den;
	endfunction

	function automatic fresnel_result_t fresnel_predict(logic [15:0] raw);
		fresnel_result_t r;
		logic neg, entering;
		logic [63:0] c, ei, et, lhs, t, rs, rp, refl;
		neg = raw[15];
		entering = !neg && raw != 0;
		c = neg ? 64'h10000 - raw : raw;
		ei = entering ? n_out : n_in;
		et = entering ? n_in : n_out;
		lhs = ei * ei * ((64'd1 << 30) - c * c);
		if (lhs >= et * et * (64'd1 << 30)) begin
			r.refl = 16'h8000;
			r.cos_t = 0;
			r.tir = 1'b1;
			return r;
		end
		t = int_sqrt((64'd1 << 30) - lhs / (et * et));
		if (ei == et) begin
			refl = 0;
		end else begin
			rs = ratio_q24(ei * c, et * t);
			rp = ratio_q24(et * c, ei * t);
			refl = (rs * rs + rp * rp) >> 34;
			if (refl > 32768) refl = 32768;
		end
		r.refl = refl[15:0];
		if (entering) r.cos_t = 16'(64'h10000 - t);
		else r.cos_t = t > 32767 ? 16'h7FFF : t[15:0];
		r.tir = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Driver: one beat per accepted start, with a drawn gap before each item.
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(fresnel_predict(cos_incident));
			end
			if (start && busy) begin
				// Hold the beat until accepted.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cos_pending.size() > 0) begin
				if (gap_pending[0] > 0) begin
					gap_left <= gap_pending[0] - 1;
					gap_pending[0] = 0;
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					cos_incident <= cos_pending.pop_front();
					void'(gap_pending.pop_front());
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		fresnel_result_t e;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", reflectance, 16'd0);
			end else begin
				e = expected_results.pop_front();
				if (reflectance !== e.refl) report_mismatch("reflectance", reflectance, e.refl);
				if (cos_transmitted !== e.cos_t)
					report_mismatch("cos_transmitted", cos_transmitted, e.cos_t);
				if (total_internal !== e.tir)
					report_mismatch("total_internal", 16'(total_internal), 16'(e.tir));
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= MAX_CYCLES) begin
			$display("FAIL fresnel_dielectric_reflectance_top");
			$finish;
		end
	end

	task automatic add_item(logic [15:0] v, int gap);
		cos_pending.push_back(v);
		gap_pending.push_back(gap);
	endtask

	task automatic drain();
		while (cos_pending.size() > 0) @(posedge clk);
		@(posedge clk);
		while (start || expected_results.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_index(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_INDEX_OUTSIDE) n_out = val;
		else n_in = val;
	endtask

	function automatic logic [15:0] random_cosine();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 40));
			1: return 16'(-$urandom_range(0, 40));
			2: return 16'($urandom_range(32700, 32767));
			3: return 16'h8000 + 16'($urandom_range(0, 60));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			add_item(random_cosine(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14));
		end
		drain();
	endtask

	initial begin
		logic [15:0] settings[8][2];
		settings = '{'{16384, 24576}, '{24576, 16384}, '{4096, 65535}, '{65535, 4096},
			'{20000, 20000}, '{4096, 4096}, '{65535, 65535}, '{0, 30000}};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, grazing, normal incidence on both sides.
		foreach (settings[k]) begin
			if (k > 0) begin
				write_index(REG_INDEX_OUTSIDE, settings[k][0]);
				write_index(REG_INDEX_INSIDE, settings[k][1]);
			end
			if (k < 2) begin
				add_item(16'h0000, 0);
				add_item(16'h7FFF, 0);
				add_item(16'h8000, 0);
				add_item(16'h8001, 3);
				add_item(16'h0001, 0);
				add_item(16'hFFFF, 0);
				add_item(16'h5A82, 1);
				add_item(16'hA57E, 0);
				add_item(16'h5555, 0);
				add_item(16'hAAAA, 0);
				drain();
			end
			random_phase(k < 2 ? 300 : 90);
		end

		// Random settings for the rest.
		for (int k = 0; k < 4; k++) begin
			write_index(REG_INDEX_OUTSIDE, 16'($urandom_range(4096, 65535)));
			write_index(REG_INDEX_INSIDE, 16'($urandom_range(4096, 65535)));
			random_phase(60);
		end

		if (errors == 0) begin
			$display("PASS fresnel_dielectric_reflectance_top");
		end else begin
			$display("FAIL fresnel_dielectric_reflectance_top");
		end
		$finish;
	end
endmodule
